/* hdl/gri_pkg.sv */
// Shared types, widths and constants of the gyro rate integrator.
`timescale 1ns / 1ps

package gri_pkg;

  localparam int AXES            = 3;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int TOTAL_WIDTH     = 32;
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_COUNT       = 4;
  localparam int CFG_INDEX_WIDTH = $clog2(CFG_COUNT);
  localparam int FRAC_BITS       = 16;

  // Time step 0.0127 in Q16
  localparam int DT_Q16   = 832;
  localparam int DT_WIDTH = $clog2(DT_Q16 + 1) + 1;
  localparam logic signed [DT_WIDTH-1:0] DT_STEP = DT_WIDTH'(DT_Q16);

  // Datapath widths
  localparam int DIFF_WIDTH  = ((SAMPLE_WIDTH + 1 > CFG_WIDTH) ? SAMPLE_WIDTH + 1 : CFG_WIDTH) + 1;
  localparam int SPAN_WIDTH  = CFG_WIDTH + 1;
  localparam int NUM_WIDTH   = DIFF_WIDTH + SPAN_WIDTH;
  localparam int QUO_WIDTH   = NUM_WIDTH + FRAC_BITS;
  localparam int MAP_WIDTH   = ((QUO_WIDTH + 1 > CFG_WIDTH + FRAC_BITS) ?
                                QUO_WIDTH + 1 : CFG_WIDTH + FRAC_BITS) + 1;
  localparam int PROD_WIDTH  = MAP_WIDTH + DT_WIDTH;
  localparam int ROUND_SHIFT = 2 * FRAC_BITS;
  localparam int RND_WIDTH   = PROD_WIDTH + 1 - ROUND_SHIFT;
  localparam int INC_WIDTH   = RND_WIDTH + 1;
  localparam int SUM_WIDTH   = ((INC_WIDTH > TOTAL_WIDTH) ? INC_WIDTH : TOTAL_WIDTH) + 1;
  localparam int DIV_COUNT_WIDTH = $clog2(QUO_WIDTH);

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAW_MIN = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAW_MAX = CFG_INDEX_WIDTH'(1);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SI_MIN  = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SI_MAX  = CFG_INDEX_WIDTH'(3);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_x;
    logic signed [SAMPLE_WIDTH-1:0] sample_y;
    logic signed [SAMPLE_WIDTH-1:0] sample_z;
  } gri_sample_t;

  typedef struct packed {
    logic signed [TOTAL_WIDTH-1:0] angle_x;
    logic signed [TOTAL_WIDTH-1:0] angle_y;
    logic signed [TOTAL_WIDTH-1:0] angle_z;
    logic                          was_calibration;
  } gri_angle_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic mul;
    logic div_start;
    logic div_step;
    logic map;
    logic scale;
    logic round;
    logic acc;
    logic out_load;
  } gri_cmd_t;

  typedef struct packed {
    logic out_busy;
  } gri_status_t;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_DIFF  = 10'b00_0000_0010,
    ST_MUL   = 10'b00_0000_0100,
    ST_START = 10'b00_0000_1000,
    ST_DIV   = 10'b00_0001_0000,
    ST_MAP   = 10'b00_0010_0000,
    ST_SCALE = 10'b00_0100_0000,
    ST_ROUND = 10'b00_1000_0000,
    ST_ACC   = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } gri_state_t;

endpackage

/* hdl/gri_div.sv */
// Restoring unsigned divider, one quotient bit per step.
`timescale 1ns / 1ps

module gri_div
  import gri_pkg::*;
(
  input  logic                  clk,
  input  logic                  start,
  input  logic                  step,
  input  logic [QUO_WIDTH-1:0]  dividend,
  input  logic [SPAN_WIDTH-1:0] divisor,
  output logic [QUO_WIDTH-1:0]  quotient
);

  logic [SPAN_WIDTH-1:0] rem;
  logic [QUO_WIDTH-1:0]  quo;
  logic [SPAN_WIDTH:0]   trial;
  logic                  fits;

  assign trial = {rem, quo[QUO_WIDTH-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (step) begin
      rem <= fits ? SPAN_WIDTH'(trial - {1'b0, divisor}) : trial[SPAN_WIDTH-1:0];
      quo <= {quo[QUO_WIDTH-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

/* hdl/gri_ctrl.sv */
// Sequencing state machine of the gyro rate integrator.
`timescale 1ns / 1ps

module gri_ctrl
  import gri_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  gri_status_t status,
  output gri_cmd_t    cmd
);

  gri_state_t                 state, state_next;
  logic [DIV_COUNT_WIDTH-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = sample_valid;
        if (sample_valid) state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        cnt_next      = DIV_COUNT_WIDTH'(QUO_WIDTH - 1);
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) state_next = ST_MAP;
        else cnt_next = cnt - 1'b1;
      end
      ST_MAP: begin
        cmd.map    = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round  = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the beat
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign sample_stall = (state != ST_IDLE);

endmodule

/* hdl/gri_datapath.sv */
// Registers, per-axis lanes and output register of the gyro rate integrator.
`timescale 1ns / 1ps

module gri_datapath
  import gri_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  gri_sample_t                sample,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  input  gri_cmd_t                   cmd,
  output gri_status_t                status,
  output logic                       angle_valid,
  input  logic                       angle_stall,
  output gri_angle_t                 angle
);

  logic signed [CFG_WIDTH-1:0] raw_min, raw_max, si_min, si_max;
  logic                        calibrated;
  logic                        was;

  logic signed [SAMPLE_WIDTH-1:0] smp     [AXES];
  logic signed [SAMPLE_WIDTH-1:0] offset  [AXES];
  logic signed [DIFF_WIDTH-1:0]   diff    [AXES];
  logic signed [NUM_WIDTH-1:0]    num     [AXES];
  logic                           neg     [AXES];
  logic signed [MAP_WIDTH-1:0]    mapped  [AXES];
  logic signed [PROD_WIDTH-1:0]   prod    [AXES];
  logic signed [INC_WIDTH-1:0]    inc     [AXES];
  logic signed [TOTAL_WIDTH-1:0]  total   [AXES];

  logic signed [SPAN_WIDTH-1:0] span, si_span;
  logic [SPAN_WIDTH-1:0]        span_mag;
  logic                         span_zero, span_neg;

  logic [QUO_WIDTH-1:0]  dividend [AXES];
  logic [QUO_WIDTH-1:0]  quo      [AXES];
  logic [NUM_WIDTH-1:0]  num_mag  [AXES];
  logic [PROD_WIDTH-1:0] prod_mag [AXES];
  logic [PROD_WIDTH:0]   rnd_sum  [AXES];
  logic signed [INC_WIDTH-1:0]   rnd_val  [AXES];
  logic signed [INC_WIDTH-1:0]   inc_next [AXES];
  logic signed [MAP_WIDTH-1:0]   quo_s    [AXES];
  logic signed [SUM_WIDTH-1:0]   sum      [AXES];
  logic signed [TOTAL_WIDTH-1:0] sat      [AXES];

  // Configuration; any write forces recalibration on the next sample
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_min    <= -16'sd32768;
      raw_max    <= 16'sd32767;
      si_min     <= -16'sd2000;
      si_max     <= 16'sd2000;
      calibrated <= 1'b0;
    end else if (cfg_we) begin
      calibrated <= 1'b0;
      unique case (cfg_index)
        REG_RAW_MIN: raw_min <= cfg_data;
        REG_RAW_MAX: raw_max <= cfg_data;
        REG_SI_MIN:  si_min  <= cfg_data;
        REG_SI_MAX:  si_max  <= cfg_data;
        default: ;
      endcase
    end else if (cmd.load) begin
      calibrated <= 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      num_mag[i]  = num[i][NUM_WIDTH-1] ? NUM_WIDTH'(-num[i]) : NUM_WIDTH'(num[i]);
      dividend[i] = {num_mag[i], {FRAC_BITS{1'b0}}};
      quo_s[i]    = MAP_WIDTH'($signed({1'b0, quo[i]}));
      prod_mag[i] = prod[i][PROD_WIDTH-1] ? PROD_WIDTH'(-prod[i]) : PROD_WIDTH'(prod[i]);
      // round half away from zero on the magnitude
      rnd_sum[i]  = {1'b0, prod_mag[i]} + ((PROD_WIDTH + 1)'(1) << (ROUND_SHIFT - 1));
      rnd_val[i]  = $signed({1'b0, rnd_sum[i][PROD_WIDTH:ROUND_SHIFT]});
      inc_next[i] = span_zero ? '0 : (prod[i][PROD_WIDTH-1] ? -rnd_val[i] : rnd_val[i]);
      sum[i]      = SUM_WIDTH'(total[i]) + SUM_WIDTH'(inc[i]);
      if (&sum[i][SUM_WIDTH-1:TOTAL_WIDTH-1] || ~|sum[i][SUM_WIDTH-1:TOTAL_WIDTH-1])
        sat[i] = sum[i][TOTAL_WIDTH-1:0];
      else if (sum[i][SUM_WIDTH-1])
        sat[i] = {1'b1, {(TOTAL_WIDTH-1){1'b0}}};
      else
        sat[i] = {1'b0, {(TOTAL_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp[0] <= sample.sample_x;
      smp[1] <= sample.sample_y;
      smp[2] <= sample.sample_z;
      was    <= !calibrated;
      if (!calibrated) begin
        offset[0] <= sample.sample_x;
        offset[1] <= sample.sample_y;
        offset[2] <= sample.sample_z;
        for (int i = 0; i < AXES; i++) total[i] <= '0;
      end
    end
    if (cmd.diff) begin
      span    <= SPAN_WIDTH'(raw_max) - SPAN_WIDTH'(raw_min);
      si_span <= SPAN_WIDTH'(si_max) - SPAN_WIDTH'(si_min);
      for (int i = 0; i < AXES; i++)
        diff[i] <= DIFF_WIDTH'(smp[i]) - DIFF_WIDTH'(offset[i]) - DIFF_WIDTH'(raw_min);
    end
    if (cmd.mul) begin
      span_zero <= (span == '0);
      span_neg  <= span[SPAN_WIDTH-1];
      span_mag  <= span[SPAN_WIDTH-1] ? SPAN_WIDTH'(-span) : SPAN_WIDTH'(span);
      for (int i = 0; i < AXES; i++)
        num[i] <= NUM_WIDTH'(diff[i]) * NUM_WIDTH'(si_span);
    end
    if (cmd.div_start) begin
      for (int i = 0; i < AXES; i++) neg[i] <= num[i][NUM_WIDTH-1] ^ span_neg;
    end
    if (cmd.map) begin
      for (int i = 0; i < AXES; i++)
        mapped[i] <= (neg[i] ? -quo_s[i] : quo_s[i]) + (MAP_WIDTH'(si_min) <<< FRAC_BITS);
    end
    if (cmd.scale) begin
      for (int i = 0; i < AXES; i++)
        prod[i] <= PROD_WIDTH'(mapped[i]) * PROD_WIDTH'(DT_STEP);
    end
    if (cmd.round) begin
      for (int i = 0; i < AXES; i++) inc[i] <= inc_next[i];
    end
    if (cmd.acc) begin
      for (int i = 0; i < AXES; i++) total[i] <= sat[i];
    end
  end

  for (genvar g = 0; g < AXES; g++) begin : g_div
    gri_div u_div (
      .clk      (clk),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (dividend[g]),
      .divisor  (span_mag),
      .quotient (quo[g])
    );
  end

  // Output register: a beat waits here while the next sample is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
    end else if (cmd.out_load) begin
      angle_valid <= 1'b1;
    end else if (!angle_stall) begin
      angle_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      angle.angle_x         <= total[0];
      angle.angle_y         <= total[1];
      angle.angle_z         <= total[2];
      angle.was_calibration <= was;
    end
  end

  assign status.out_busy = angle_valid && angle_stall;

endmodule

/* hdl/gyro_rate_integrator.sv */
// Top level of the three-axis gyro rate integrator.
//
// Sample channel: sample_valid / sample_stall / sample carry one three-axis
// raw beat, taken at an edge where valid is high and stall is low.
// Angle channel: angle_valid / angle_stall / angle return one beat per
// sample with the three saturating totals and the calibration flag.
// Config port: cfg_we / cfg_index / cfg_data write one 16-bit register per
// edge (0 raw_min, 1 raw_max, 2 si_min, 3 si_max); any write makes the next
// sample the new zero offset and clears the totals.
// A new sample is taken only once the previous one has reached the output
// register; the pace is set by the three restoring dividers, one per lane,
// each producing one of its 51 quotient bits per cycle.
// The result sits in an output register, so a new sample is taken while the
// previous beat is still stalled; the block only waits at the end of the next
// sample if that earlier beat has still not gone.
// Reset (rst, synchronous) restores the register defaults, drops any pending
// beat and makes the first sample a calibration sample.
`timescale 1ns / 1ps

module gyro_rate_integrator
  import gri_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  gri_sample_t                sample,
  output logic                       angle_valid,
  input  logic                       angle_stall,
  output gri_angle_t                 angle,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data
);

  gri_cmd_t    cmd;
  gri_status_t status;

  gri_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  gri_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .angle_valid (angle_valid),
    .angle_stall (angle_stall),
    .angle       (angle)
  );

endmodule
